### rtl/core/fbnp_pkg.sv
package fbnp_pkg;

    // Palette geometry.
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int LEN_W         = IDX_W + 1;

    // Fixed point level: 17 bits holds 0 through one.
    localparam int           LVL_W   = 17;
    localparam logic [16:0]  FOG_ONE = 17'h10000;

    // Result index reported when the search window is empty.
    localparam logic [7:0]   EMPTY_INDEX = 8'd127;

    // Configuration register indexes.
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  REG_FOG_RED      = 3'd0;
    localparam logic [2:0]  REG_FOG_GREEN    = 3'd1;
    localparam logic [2:0]  REG_FOG_BLUE     = 3'd2;
    localparam logic [2:0]  REG_SEARCH_BASE  = 3'd3;
    localparam logic [2:0]  REG_SEARCH_COUNT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_FOG_CHANNEL  = 8'd128;
    localparam logic [7:0]  RST_SEARCH_BASE  = 8'd0;
    localparam logic [8:0]  RST_SEARCH_COUNT = 9'd256;

    // Input mode codes.
    localparam logic        MODE_LOAD  = 1'b0;
    localparam logic        MODE_QUERY = 1'b1;

    // Channel selects for the shared blend multiplier.
    localparam logic [1:0]  CH_RED   = 2'd0;
    localparam logic [1:0]  CH_GREEN = 2'd1;
    localparam logic [1:0]  CH_BLUE  = 2'd2;
    localparam logic [1:0]  CH_DONE  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLEND,
        S_SEARCH,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

### rtl/core/fog_blend_nearest_palette.sv
// Fog blend and nearest palette color search.
//
// Input items arrive on a valid/ready channel (i_valid, o_ready). A load
// item (i_mode low) writes one 24-bit palette entry in the cycle of its
// transfer and gives no result. A query item (i_mode high) clamps its fog
// level to [0, one], blends the source color toward the configured fog color
// with one shared multiplier, one channel a cycle, then walks the configured
// palette window through a three stage read, square and compare pipeline at
// one entry per cycle. The result leaves on a valid/ready channel
// (o_valid, i_ready) through an output register.
// A query raises o_valid after its blend, its walk over the N entries of the
// window (at most 256) and the drain of the compare pipeline; an empty window
// reads no entries. The block is ready again after it loads the result into
// the output register; the palette walk at one memory read per cycle sets the
// length of a full palette query.
// The block takes no new item while a query is in flight. A finished result
// sits in the output register; if the receiver stalls, the block still takes
// the next item, and a second result waits in the sequencer until the
// register is free. Reset (synchronous, active low) returns the sequencer to
// idle, clears the output valid and restores the configuration registers;
// palette contents are undefined until loaded.
module fog_blend_nearest_palette
    import fbnp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [8:0]            i_cfg_wdata,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [7:0]            i_entry_index,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic signed [18:0]    i_fog_level,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_nearest_index,
    output logic [7:0]            o_fogged_red,
    output logic [7:0]            o_fogged_green,
    output logic [7:0]            o_fogged_blue,
    output logic [17:0]           o_best_distance
);

    // Configuration registers.
    logic [7:0]       r_fog_red;
    logic [7:0]       r_fog_green;
    logic [7:0]       r_fog_blue;
    logic [7:0]       r_search_base;
    logic [8:0]       r_search_count;

    // Sequencer.
    t_state           r_state;
    t_state           n_state;

    // Query operands.
    logic [7:0]       r_src_red;
    logic [7:0]       r_src_green;
    logic [7:0]       r_src_blue;
    logic [LVL_W-1:0] r_level;

    // Shared blend multiplier.
    logic [1:0]         r_bcnt;
    logic               r_pvld;
    logic [1:0]         r_pch;
    logic signed [26:0] r_prod;

    // Blended color.
    logic [7:0]       r_fr;
    logic [7:0]       r_fg;
    logic [7:0]       r_fb;

    // Palette walk.
    logic [IDX_W-1:0] r_addr;
    logic [LEN_W-1:0] r_left;

    logic [23:0]      r_mem [PALETTE_DEPTH];
    logic [23:0]      r_rd_data;
    logic             r_v1;
    logic [IDX_W-1:0] r_i1;
    logic [17:0]      r_dist;
    logic             r_v2;
    logic [IDX_W-1:0] r_i2;

    // Running best.
    logic             r_found;
    logic [7:0]       r_best_i;
    logic [17:0]      r_best_d;

    // Output register.
    logic             r_out_valid;
    logic [7:0]       r_out_index;
    logic [7:0]       r_out_red;
    logic [7:0]       r_out_green;
    logic [7:0]       r_out_blue;
    logic [17:0]      r_out_dist;

    // Control decoded from the state.
    logic             in_xfer;
    logic             load_we;
    logic             query_start;
    logic             mul_issue;
    logic             rd_issue;
    logic             out_load;

    // Datapath nets.
    logic [LVL_W-1:0]   level_clamped;
    logic [LEN_W-1:0]   win_avail;
    logic [LEN_W-1:0]   win_len;
    logic               win_empty;
    logic signed [17:0] mul_a;
    logic signed [8:0]  mul_b;
    logic signed [26:0] mul_p;
    logic [7:0]         blend_src;
    logic signed [26:0] blend_sum;
    logic signed [8:0]  dr;
    logic signed [8:0]  dg;
    logic signed [8:0]  db;
    logic signed [17:0] dr_sq;
    logic signed [17:0] dg_sq;
    logic signed [17:0] db_sq;
    logic [17:0]        dist_sum;

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_mode == MODE_QUERY) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                if (r_bcnt == CH_DONE) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // The last read goes out in the cycle that sees one entry left.
                if (r_left <= LEN_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs of the sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        o_ready   = 1'b0;
        mul_issue = 1'b0;
        rd_issue  = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_BLEND: begin
                mul_issue = (r_bcnt != CH_DONE);
            end
            S_SEARCH: begin
                rd_issue = (r_left != '0);
            end
            S_DRAIN: begin
                o_ready = 1'b0;
            end
            S_DONE: begin
                out_load = !r_out_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign in_xfer     = i_valid && o_ready;
    assign load_we     = in_xfer && i_mode == MODE_LOAD
                         && {1'b0, i_entry_index} < LEN_W'(PALETTE_DEPTH);
    assign query_start = in_xfer && i_mode == MODE_QUERY;

    // ------------------------------------------------------------------
    // Level clamp and window bounds, taken at the query transfer.
    // ------------------------------------------------------------------
    always_comb begin
        if (i_fog_level[18]) begin
            level_clamped = '0;
        end else if (i_fog_level[17:0] > {1'b0, FOG_ONE}) begin
            level_clamped = FOG_ONE;
        end else begin
            level_clamped = i_fog_level[16:0];
        end
    end

    assign win_empty = (r_search_count == '0)
                       || ({1'b0, r_search_base} >= LEN_W'(PALETTE_DEPTH));
    assign win_avail = LEN_W'(PALETTE_DEPTH) - {1'b0, r_search_base};

    always_comb begin
        if (win_empty) begin
            win_len = '0;
        end else if (LEN_W'(r_search_count) < win_avail) begin
            win_len = LEN_W'(r_search_count);
        end else begin
            win_len = win_avail;
        end
    end

    // ------------------------------------------------------------------
    // Shared blend multiplier. Each channel is src + L * (fog - src) / one,
    // which equals the weighted sum of fog and source before truncation.
    // ------------------------------------------------------------------
    assign mul_a = $signed({1'b0, r_level});

    always_comb begin
        case (r_bcnt)
            CH_RED:   mul_b = $signed({1'b0, r_fog_red})   - $signed({1'b0, r_src_red});
            CH_GREEN: mul_b = $signed({1'b0, r_fog_green}) - $signed({1'b0, r_src_green});
            CH_BLUE:  mul_b = $signed({1'b0, r_fog_blue})  - $signed({1'b0, r_src_blue});
            default:  mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        case (r_pch)
            CH_RED:   blend_src = r_src_red;
            CH_GREEN: blend_src = r_src_green;
            CH_BLUE:  blend_src = r_src_blue;
            default:  blend_src = '0;
        endcase
    end

    // The exact sum is never negative and stays below 256 * one.
    assign blend_sum = $signed({3'b000, blend_src, 16'h0000}) + r_prod;

    // ------------------------------------------------------------------
    // Distance of the entry read last cycle to the blended color.
    // ------------------------------------------------------------------
    assign dr       = $signed({1'b0, r_rd_data[23:16]}) - $signed({1'b0, r_fr});
    assign dg       = $signed({1'b0, r_rd_data[15:8]})  - $signed({1'b0, r_fg});
    assign db       = $signed({1'b0, r_rd_data[7:0]})   - $signed({1'b0, r_fb});
    assign dr_sq    = dr * dr;
    assign dg_sq    = dg * dg;
    assign db_sq    = db * db;
    assign dist_sum = 18'(dr_sq[15:0]) + 18'(dg_sq[15:0]) + 18'(db_sq[15:0]);

    // ------------------------------------------------------------------
    // Palette memory.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem[i_entry_index[IDX_W-1:0]] <= {i_red, i_green, i_blue};
        end
        r_rd_data <= r_mem[r_addr];
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fog_red      <= RST_FOG_CHANNEL;
            r_fog_green    <= RST_FOG_CHANNEL;
            r_fog_blue     <= RST_FOG_CHANNEL;
            r_search_base  <= RST_SEARCH_BASE;
            r_search_count <= RST_SEARCH_COUNT;
            r_bcnt         <= CH_RED;
            r_pvld         <= 1'b0;
            r_left         <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_FOG_RED:      r_fog_red      <= i_cfg_wdata[7:0];
                    REG_FOG_GREEN:    r_fog_green    <= i_cfg_wdata[7:0];
                    REG_FOG_BLUE:     r_fog_blue     <= i_cfg_wdata[7:0];
                    REG_SEARCH_BASE:  r_search_base  <= i_cfg_wdata[7:0];
                    REG_SEARCH_COUNT: r_search_count <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (query_start) begin
                r_bcnt <= CH_RED;
            end else if (mul_issue) begin
                r_bcnt <= r_bcnt + 2'd1;
            end
            r_pvld <= mul_issue;

            if (query_start) begin
                r_left <= win_len;
            end else if (rd_issue) begin
                r_left <= r_left - LEN_W'(1);
            end
            r_v1 <= rd_issue;
            r_v2 <= r_v1;

            if (query_start) begin
                r_found <= 1'b0;
            end else if (r_v2 && (!r_found || r_dist < r_best_d)) begin
                r_found <= 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (query_start) begin
            r_src_red   <= i_red;
            r_src_green <= i_green;
            r_src_blue  <= i_blue;
            r_level     <= level_clamped;
            r_addr      <= r_search_base[IDX_W-1:0];
            r_best_i    <= EMPTY_INDEX;
            r_best_d    <= '0;
        end else begin
            if (rd_issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (r_v2 && (!r_found || r_dist < r_best_d)) begin
                r_best_i <= 8'(r_i2);
                r_best_d <= r_dist;
            end
        end

        if (mul_issue) begin
            r_prod <= mul_p;
            r_pch  <= r_bcnt;
        end

        if (r_pvld) begin
            case (r_pch)
                CH_RED:   r_fr <= blend_sum[23:16];
                CH_GREEN: r_fg <= blend_sum[23:16];
                CH_BLUE:  r_fb <= blend_sum[23:16];
                default: begin
                end
            endcase
        end

        r_i1   <= r_addr;
        r_i2   <= r_i1;
        r_dist <= dist_sum;

        if (out_load) begin
            r_out_index <= r_best_i;
            r_out_red   <= r_fr;
            r_out_green <= r_fg;
            r_out_blue  <= r_fb;
            r_out_dist  <= r_best_d;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_nearest_index = r_out_index;
    assign o_fogged_red    = r_out_red;
    assign o_fogged_green  = r_out_green;
    assign o_fogged_blue   = r_out_blue;
    assign o_best_distance = r_out_dist;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_read_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_state == S_SEARCH || r_state == S_DRAIN))
        else $error("palette read in flight outside the walk");

    a_done_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_v1 && !r_v2))
        else $error("result taken while the compare pipeline still holds entries");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_found) |-> (r_best_i == EMPTY_INDEX && r_best_d == '0))
        else $error("empty window gave a nonempty answer");

    a_blend_before_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_bcnt == CH_DONE && !mul_issue))
        else $error("palette walk started before the blend finished");

endmodule
